// ===== hdl/rmp_pkg.sv =====
package rmp_pkg;

	localparam int ID_W    = 8;
	localparam int RATE_W  = 7;
	localparam int DIM_W   = 16;
	localparam int ENTRY_W = ID_W + RATE_W;
	localparam int NUM_W   = 24;

	localparam logic [RATE_W-1:0] FULL_PERCENT = 7'd100;

	// Configuration register indexes.
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_PART_RD,
		ST_PART_MUL,
		ST_PART_DIV,
		ST_PART_OUT
	} state_t;

endpackage

// ===== hdl/rmp_div.sv =====
module rmp_div #(
	parameter int SW = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rmp_pkg::NUM_W-1:0] num,
	input  logic [SW-1:0]            den,
	output logic                     done,
	output logic [rmp_pkg::DIM_W-1:0] quo
);

	localparam int NW = rmp_pkg::NUM_W;
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0]    shift_q;
	logic [SW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SW:0]      trial;
	logic             qbit;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, shift_q[NW-1]};
	assign qbit  = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits as it shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= num;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[NW-2:0], qbit};
			rem_q   <= qbit ? SW'(trial - {1'b0, den}) : trial[SW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = shift_q[rmp_pkg::DIM_W-1:0];

endmodule

// ===== hdl/rated_matrix_partitioner.sv =====
// Rated matrix partitioner.
// Requests on the input channel (in_valid/in_ready) carry a node id, a rating
// in percent (saturated to 100) and a last flag. Each request is inserted into
// an on-chip table kept sorted by ascending rating; equal ratings keep arrival
// order. Insertion walks the table one entry per cycle through the single
// table read port. A request with last set starts the partition of a
// matrix_rows x matrix_cols matrix: one pass sums the ratings (a read and an
// accumulate state per entry), then each node gets one rectangle on the output
// channel (out_valid/out_ready), cut alternately along columns and rows. Each
// rectangle passes a read, a multiply and an output state, with a divide state
// before the output when a division is needed; the bit-serial divider holds
// the walk until it is done. last_slice marks the final rectangle.
// The block handles one request at a time; in_ready is low while it inserts
// or partitions. A stalled receiver holds the current rectangle in its output
// register and the block waits. Table size is MAX_NODES; extra requests are
// dropped, but a dropped last request still starts partitioning.
// The configuration port writes matrix_rows (index 0) or matrix_cols
// (index 1); the user must write only while idle, as the block does not check.
// Reset empties the table, clears both registers and needs no clearing pass.
module rated_matrix_partitioner #(
	parameter int MAX_NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  node_id,
	input  logic [6:0]  rating,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  proc_id,
	output logic [15:0] col_start,
	output logic [15:0] row_start,
	output logic [15:0] slice_cols,
	output logic [15:0] slice_rows,
	output logic        last_slice
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = $clog2(MAX_NODES * 100 + 1);
	localparam int RW = rmp_pkg::RATE_W;
	localparam int IW = rmp_pkg::ID_W;
	localparam int DW = rmp_pkg::DIM_W;
	localparam int EW = rmp_pkg::ENTRY_W;
	localparam int NW = rmp_pkg::NUM_W;

	rmp_pkg::state_t state_q, state_n;

	logic [EW-1:0] mem [MAX_NODES];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en;

	logic [CW-1:0] count_q, pos_q, k_q;
	logic [IW-1:0] new_id_q;
	logic [RW-1:0] new_rate_q;
	logic          new_last_q;
	logic [SW-1:0] rate_sum_q, inv_sum_q;
	logic [DW-1:0] rows_q, cols_q;
	logic [DW-1:0] row_org_q, col_org_q, rows_left_q, cols_left_q;
	logic          cut_q;
	logic [EW-1:0] ent_q;
	logic [DW-1:0] pivot_q;
	logic [NW-1:0] num_q;
	logic          div_go_q;

	logic [RW-1:0] in_rate;
	logic          accept, full, rd_gt, final_k, div_start, div_done;
	logic [RW-1:0] rd_rate, ent_rate, rd_inv;
	logic [DW-1:0] dim, div_quo;
	logic [CW-1:0] remaining;

	assign in_rate  = (rating > rmp_pkg::FULL_PERCENT) ? rmp_pkg::FULL_PERCENT : rating;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(MAX_NODES));
	assign rd_rate  = rd_q[RW-1:0];
	assign rd_gt    = (rd_rate > new_rate_q);
	assign ent_rate = ent_q[RW-1:0];
	assign rd_inv   = rmp_pkg::FULL_PERCENT - rd_rate;
	assign dim      = cut_q ? cols_left_q : rows_left_q;
	assign remaining = count_q - k_q;
	assign final_k  = (k_q + 1'b1 == count_q);
	assign div_start = (state_q == rmp_pkg::ST_PART_MUL) && (remaining > CW'(1))
		&& (rate_sum_q != '0) && (inv_sum_q != '0);

	// Sorted table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rmp_pkg::ST_IDLE: begin
				if (accept) begin
					if (full || count_q == '0) begin
						state_n = last ? rmp_pkg::ST_SUM_RD : rmp_pkg::ST_IDLE;
					end else begin
						state_n = rmp_pkg::ST_INS_CMP;
					end
				end
			end
			rmp_pkg::ST_INS_CMP: begin
				if (rd_gt) begin
					state_n = (pos_q == CW'(1)) ? rmp_pkg::ST_INS_PUT : rmp_pkg::ST_INS_CMP;
				end else begin
					state_n = new_last_q ? rmp_pkg::ST_SUM_RD : rmp_pkg::ST_IDLE;
				end
			end
			rmp_pkg::ST_INS_PUT: begin
				state_n = new_last_q ? rmp_pkg::ST_SUM_RD : rmp_pkg::ST_IDLE;
			end
			rmp_pkg::ST_SUM_RD:   state_n = rmp_pkg::ST_SUM_ACC;
			rmp_pkg::ST_SUM_ACC: begin
				state_n = final_k ? rmp_pkg::ST_PART_RD : rmp_pkg::ST_SUM_RD;
			end
			rmp_pkg::ST_PART_RD:  state_n = rmp_pkg::ST_PART_MUL;
			rmp_pkg::ST_PART_MUL: begin
				state_n = div_start ? rmp_pkg::ST_PART_DIV : rmp_pkg::ST_PART_OUT;
			end
			rmp_pkg::ST_PART_DIV: begin
				if (div_done) begin
					state_n = rmp_pkg::ST_PART_OUT;
				end
			end
			rmp_pkg::ST_PART_OUT: begin
				if (out_ready) begin
					state_n = final_k ? rmp_pkg::ST_IDLE : rmp_pkg::ST_PART_RD;
				end
			end
			default: state_n = rmp_pkg::ST_IDLE;
		endcase
	end

	// Table access and handshake outputs.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pos_q[AW-1:0];
		wr_data   = {new_id_q, new_rate_q};
		rd_addr   = k_q[AW-1:0];
		unique case (state_q)
			rmp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = AW'(count_q - 1'b1);
				wr_addr  = '0;
				wr_data  = {node_id, in_rate};
				wr_en    = accept && (count_q == '0);
			end
			rmp_pkg::ST_INS_CMP: begin
				rd_addr = AW'(pos_q - CW'(2));
				wr_en   = 1'b1;
				wr_data = rd_gt ? rd_q : {new_id_q, new_rate_q};
			end
			rmp_pkg::ST_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
			end
			rmp_pkg::ST_PART_OUT: out_valid = 1'b1;
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmp_pkg::ST_IDLE;
			count_q     <= '0;
			rows_q      <= '0;
			cols_q      <= '0;
			row_org_q   <= '0;
			col_org_q   <= '0;
			rows_left_q <= '0;
			cols_left_q <= '0;
			cut_q       <= 1'b1;
			k_q         <= '0;
			pos_q       <= '0;
			div_go_q    <= 1'b0;
		end else begin
			state_q  <= state_n;
			div_go_q <= div_start;
			if (cfg_we) begin
				if (cfg_index == rmp_pkg::REG_ROWS) begin
					rows_q <= cfg_data;
				end else begin
					cols_q <= cfg_data;
				end
			end
			unique case (state_q)
				rmp_pkg::ST_IDLE: begin
					pos_q <= count_q;
					k_q   <= '0;
					if (accept && count_q == '0) begin
						count_q <= CW'(1);
					end
				end
				rmp_pkg::ST_INS_CMP: begin
					if (rd_gt) begin
						pos_q <= pos_q - 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				rmp_pkg::ST_INS_PUT: count_q <= count_q + 1'b1;
				rmp_pkg::ST_SUM_ACC: begin
					if (final_k) begin
						k_q         <= '0;
						row_org_q   <= '0;
						col_org_q   <= '0;
						rows_left_q <= rows_q;
						cols_left_q <= cols_q;
						cut_q       <= 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				rmp_pkg::ST_PART_OUT: begin
					if (out_ready) begin
						if (cut_q) begin
							col_org_q   <= col_org_q + pivot_q;
							cols_left_q <= cols_left_q - pivot_q;
						end else begin
							row_org_q   <= row_org_q + pivot_q;
							rows_left_q <= rows_left_q - pivot_q;
						end
						cut_q <= !cut_q;
						k_q   <= k_q + 1'b1;
						if (final_k) begin
							count_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			new_id_q   <= node_id;
			new_rate_q <= in_rate;
			new_last_q <= last;
		end
		if (state_q == rmp_pkg::ST_IDLE) begin
			rate_sum_q <= '0;
			inv_sum_q  <= '0;
		end else if (state_q == rmp_pkg::ST_SUM_ACC) begin
			rate_sum_q <= rate_sum_q + SW'(rd_rate);
			inv_sum_q  <= inv_sum_q + SW'(rd_inv);
		end else if (state_q == rmp_pkg::ST_PART_OUT && out_ready) begin
			rate_sum_q <= rate_sum_q - SW'(ent_rate);
			inv_sum_q  <= inv_sum_q - SW'(rmp_pkg::FULL_PERCENT - ent_rate);
		end
		if (state_q == rmp_pkg::ST_PART_MUL) begin
			ent_q <= rd_q;
			num_q <= NW'(dim) * NW'(rd_inv) + NW'(inv_sum_q) - NW'(1);
			pivot_q <= (remaining <= CW'(1)) ? dim : '0;
		end else if (state_q == rmp_pkg::ST_PART_DIV && div_done) begin
			pivot_q <= div_quo;
		end
	end

	// The divider start is registered in the same cycle as the dividend.
	rmp_div #(
		.SW(SW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go_q),
		.num   (num_q),
		.den   (inv_sum_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign proc_id    = ent_q[EW-1:RW];
	assign col_start  = col_org_q;
	assign row_start  = row_org_q;
	assign slice_cols = cut_q ? pivot_q : cols_left_q;
	assign slice_rows = cut_q ? rows_left_q : pivot_q;
	assign last_slice = final_k;

`ifndef SYNTHESIS
	// Input and output never handshake in the same cycle.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output active together");
	// The table never holds more than its depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NODES)) else $error("node count overflow");
	// The final rectangle empties the table.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_slice |=> count_q == '0)
		else $error("table not emptied after partition");
`endif

endmodule

// ===== sim/tb_rated_matrix_partitioner.sv =====
`timescale 1ns / 100ps

// One rectangle as the block reports it.
typedef struct packed {
	logic [7:0]  proc_id;
	logic [15:0] col_start;
	logic [15:0] row_start;
	logic [15:0] slice_cols;
	logic [15:0] slice_rows;
	logic        last_slice;
} rect_t;

// Tracks the sorted rating table and predicts the rectangles of each job.
class partition_scoreboard;
	logic [7:0]  node_ids[16];
	logic [6:0]  node_rates[16];
	int unsigned stored;
	logic [15:0] dim_rows;
	logic [15:0] dim_cols;
	rect_t       rects_due[$];
	int unsigned mismatches;

	function new();
		stored = 0;
		dim_rows = '0;
		dim_cols = '0;
		mismatches = 0;
	endfunction

	// Share of the remaining dimension for table entry k.
	function logic [15:0] share(int unsigned k, logic [15:0] dim);
		int unsigned rate_sum;
		int unsigned inv_sum;
		int unsigned inv;
		rate_sum = 0;
		inv_sum = 0;
		if (stored - k <= 1)
			return dim;
		for (int unsigned i = k; i < stored; i++) begin
			rate_sum += node_rates[i];
			inv_sum += 100 - node_rates[i];
		end
		if (rate_sum == 0 || inv_sum == 0)
			return '0;
		inv = 100 - node_rates[k];
		return 16'((dim * inv + inv_sum - 1) / inv_sum);
	endfunction

	// Accepted request: insert in order, and on last cut the matrix.
	function void note_request(logic [7:0] id, logic [6:0] rate, logic last);
		int unsigned pos;
		logic [15:0] c_org, r_org, c_left, r_left, cut;
		logic by_cols;
		rect_t r;
		if (rate > rmp_pkg::FULL_PERCENT)
			rate = rmp_pkg::FULL_PERCENT;
		if (stored < 16) begin
			pos = stored;
			while (pos > 0 && node_rates[pos-1] > rate) begin
				node_ids[pos] = node_ids[pos-1];
				node_rates[pos] = node_rates[pos-1];
				pos--;
			end
			node_ids[pos] = id;
			node_rates[pos] = rate;
			stored++;
		end
		if (!last)
			return;
		c_org = '0;
		r_org = '0;
		c_left = dim_cols;
		r_left = dim_rows;
		by_cols = 1'b1;
		for (int unsigned k = 0; k < stored; k++) begin
			r.proc_id = node_ids[k];
			r.col_start = c_org;
			r.row_start = r_org;
			if (by_cols) begin
				cut = share(k, c_left);
				r.slice_cols = cut;
				r.slice_rows = r_left;
				c_org += cut;
				c_left -= cut;
			end else begin
				cut = share(k, r_left);
				r.slice_cols = c_left;
				r.slice_rows = cut;
				r_org += cut;
				r_left -= cut;
			end
			r.last_slice = (k + 1 == stored);
			rects_due.insert(rects_due.size(), r);
			by_cols = !by_cols;
		end
		stored = 0;
	endfunction

	// Accepted rectangle: compare with the oldest prediction.
	function void check_rect(rect_t got);
		rect_t want;
		if (rects_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected rectangle %p", got);
			return;
		end
		want = rects_due[0];
		rects_due.delete(0);
		if (got.proc_id != want.proc_id || got.col_start != want.col_start ||
		    got.row_start != want.row_start || got.slice_cols != want.slice_cols ||
		    got.slice_rows != want.slice_rows || got.last_slice != want.last_slice) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: rectangle mismatch, expected %p, got %p", want, got);
		end
	endfunction
endclass

module tb_rated_matrix_partitioner;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  node_id;
	logic [6:0]  rating;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  proc_id;
	logic [15:0] col_start;
	logic [15:0] row_start;
	logic [15:0] slice_cols;
	logic [15:0] slice_rows;
	logic        last_slice;

	partition_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_cycles;
	int unsigned phase_reqs;

	rated_matrix_partitioner u_dut (.*);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung run.
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Check every accepted rectangle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_rect({proc_id, col_start, row_start, slice_cols, slice_rows,
				last_slice});
	end

	// Receiver: long hold-off when asked, otherwise random stalls.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rmp_pkg::REG_ROWS)
			sb.dim_rows = value;
		else
			sb.dim_cols = value;
	endtask

	// Offer one request and wait for it to be taken; returns at a falling edge.
	task automatic send_request(logic [7:0] id, logic [6:0] rate, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		node_id <= id;
		rating <= rate;
		last <= fin;
		do @(posedge clk); while (!in_ready);
		sb.note_request(id, rate, fin);
		phase_reqs++;
		@(negedge clk);
	endtask

	function automatic logic [6:0] pick_rate();
		unique case ($urandom_range(9))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'($urandom_range(127, 101));
			default: return 7'($urandom_range(100));
		endcase
	endfunction

	// One job of n requests with random content; the final one is marked last.
	task automatic send_job(int unsigned n);
		int unsigned style;
		logic [6:0] common;
		style = $urandom_range(7);
		common = pick_rate();
		for (int unsigned i = 0; i < n; i++)
			send_request(8'($urandom), (style == 0) ? common : pick_rate(), i + 1 == n);
	endtask

	// Stop offering, wait for all rectangles, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.rects_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		cfg_we = 1'b0;
		cfg_index = rmp_pkg::REG_ROWS;
		cfg_data = '0;
		in_valid = 1'b0;
		node_id = '0;
		rating = '0;
		last = 1'b0;
		out_ready = 1'b0;
		hold_cycles = 0;
		send_idle_pct = 8;
		recv_idle_pct = 85;
		phase_reqs = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme ids and ratings, saturation, ties, one node.
		write_reg(rmp_pkg::REG_ROWS, 16'hFFFF);
		write_reg(rmp_pkg::REG_COLS, 16'hFFFF);
		send_request(8'd255, 7'd100, 1'b0);
		send_request(8'd0, 7'd0, 1'b0);
		send_request(8'd1, 7'd127, 1'b0);
		send_request(8'd2, 7'd50, 1'b0);
		send_request(8'd3, 7'd50, 1'b1);
		send_request(8'd170, 7'd85, 1'b1);
		// All remaining ratings zero, then all at full percent.
		send_request(8'd85, 7'd0, 1'b0);
		send_request(8'd86, 7'd0, 1'b1);
		send_request(8'd87, 7'd100, 1'b0);
		send_request(8'd88, 7'd101, 1'b1);
		drain();
		// Overfull table: the dropped last request still starts the cut.
		write_reg(rmp_pkg::REG_ROWS, 16'd0);
		write_reg(rmp_pkg::REG_COLS, 16'd37);
		for (int unsigned i = 0; i < 17; i++)
			send_request(8'(i * 15), 7'($urandom_range(100)), i == 16);
		drain();

		// Random phases under three idling schemes and several matrix sizes.
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 85 : 0;
			recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 8 : 0;
			case (ph)
				0: begin
					write_reg(rmp_pkg::REG_ROWS, 16'hFFFF);
					write_reg(rmp_pkg::REG_COLS, 16'hFFFF);
				end
				1: begin
					write_reg(rmp_pkg::REG_ROWS, 16'd0);
					write_reg(rmp_pkg::REG_COLS, 16'd0);
				end
				2: begin
					write_reg(rmp_pkg::REG_ROWS, 16'd1);
					write_reg(rmp_pkg::REG_COLS, 16'hFFFF);
				end
				3: begin
					write_reg(rmp_pkg::REG_ROWS, 16'hFFFF);
					write_reg(rmp_pkg::REG_COLS, 16'd1);
				end
				default: begin
					write_reg(rmp_pkg::REG_ROWS, 16'($urandom));
					write_reg(rmp_pkg::REG_COLS, 16'($urandom_range(60)));
				end
			endcase
			// Stall the receiver long enough for the block to back up.
			if (ph == 4)
				hold_cycles = 400;
			phase_reqs = 0;
			while (phase_reqs < 35)
				send_job(($urandom_range(9) == 0) ? $urandom_range(20, 17)
					: $urandom_range(16, 1));
			drain();
		end

		if (sb.mismatches == 0 && sb.rects_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/rmp_pkg.sv
hdl/rmp_div.sv
hdl/rated_matrix_partitioner.sv
sim/tb_rated_matrix_partitioner.sv
